[design/scpf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scpf_pkg
// Shared types and constants of the checksum packet framer: register
// indexes, reset values, queue entry layout and serializer steps.
// ----------------------------------------------------------------------------
package scpf_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 11;
    localparam int SUM_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int QDEPTH      = 4;
    localparam int MAX_PAYLOAD = 1024;

    localparam logic [BYTE_W-1:0] MAGIC_FIRST  = 8'h88;
    localparam logic [BYTE_W-1:0] MAGIC_SECOND = 8'h33;
    localparam logic [BYTE_W-1:0] TRAILER_ZERO = 8'h00;

    localparam logic [BYTE_W-1:0] CMD_RESET  = 8'h04;
    localparam logic [BYTE_W-1:0] FLAG_RESET = 8'h00;
    localparam logic [LEN_W-1:0]  LEN_RESET  = 11'd640;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COMMAND = 2'd0,
        CFG_FLAG    = 2'd1,
        CFG_LENGTH  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [BYTE_W-1:0] cmd;
        logic [BYTE_W-1:0] flag;
        logic [LEN_W-1:0]  len;
    } t_cfg;

    // One accepted input byte, classified by the front end.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              hdr;   // header precedes this byte
        logic              tail;  // trailer follows this byte
        logic [BYTE_W-1:0] cmd;
        logic [BYTE_W-1:0] flag;
        logic [LEN_W-1:0]  len;
        logic [SUM_W-1:0]  sum;   // checksum including this byte
    } t_entry;

    typedef enum logic [3:0] {
        STEP_MAGIC0  = 4'd0,
        STEP_MAGIC1  = 4'd1,
        STEP_CMD     = 4'd2,
        STEP_FLAG    = 4'd3,
        STEP_LEN_LO  = 4'd4,
        STEP_LEN_HI  = 4'd5,
        STEP_DATA    = 4'd6,
        STEP_SUM_LO  = 4'd7,
        STEP_SUM_HI  = 4'd8,
        STEP_ACK     = 4'd9,
        STEP_STATUS  = 4'd10
    } t_step;

endpackage
`default_nettype wire

[design/scpf_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scpf_front
// Accepts payload bytes, tracks the packet position and running checksum,
// and writes one classified entry per byte into the queue.
// ----------------------------------------------------------------------------
module scpf_front #(
    parameter int MAX_PAYLOAD = scpf_pkg::MAX_PAYLOAD
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_push,
    input  wire                             i_full,
    input  wire [scpf_pkg::BYTE_W-1:0]      i_data,
    input  scpf_pkg::t_cfg                  i_cfg,
    output logic                            o_wr,
    output scpf_pkg::t_entry                o_entry
);

    localparam int LEN_W   = scpf_pkg::LEN_W;
    localparam int SUM_W   = scpf_pkg::SUM_W;
    localparam int LEN_TOP = (1 << LEN_W) - 1;
    localparam int EFF_MAX = (MAX_PAYLOAD > LEN_TOP) ? LEN_TOP : MAX_PAYLOAD;
    localparam int POS_W   = (EFF_MAX > 1) ? $clog2(EFF_MAX) : 1;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(EFF_MAX);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [SUM_W-1:0] r_sum, n_sum;

    logic [LEN_W-1:0] eff_len;
    logic [LEN_W:0]   pos_inc;
    logic [SUM_W-1:0] seed;
    logic [SUM_W-1:0] sum_new;
    logic             start;
    logic             close;

    always_comb begin
        if (i_cfg.len == '0) begin
            eff_len = LEN_W'(1);
        end else if (i_cfg.len > LEN_CAP) begin
            eff_len = LEN_CAP;
        end else begin
            eff_len = i_cfg.len;
        end
    end

    assign start   = (r_pos == '0);
    assign seed    = SUM_W'(i_cfg.cmd) + SUM_W'(i_cfg.flag)
                   + SUM_W'(eff_len[7:0]) + SUM_W'(eff_len[LEN_W-1:8]);
    assign sum_new = (start ? seed : r_sum) + SUM_W'(i_data);
    assign pos_inc = {{(LEN_W + 1 - POS_W){1'b0}}, r_pos} + (LEN_W + 1)'(1);
    assign close   = (pos_inc >= {1'b0, eff_len});

    assign o_wr          = i_push & ~i_full;
    assign o_entry.data  = i_data;
    assign o_entry.hdr   = start;
    assign o_entry.tail  = close;
    assign o_entry.cmd   = i_cfg.cmd;
    assign o_entry.flag  = i_cfg.flag;
    assign o_entry.len   = eff_len;
    assign o_entry.sum   = sum_new;

    // Advance position and sum per accepted byte; clear both on packet close.
    always_comb begin
        n_pos = r_pos;
        n_sum = r_sum;
        if (o_wr) begin
            n_pos = close ? '0 : pos_inc[POS_W-1:0];
            n_sum = close ? '0 : sum_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_sum <= '0;
        end else begin
            r_pos <= n_pos;
            r_sum <= n_sum;
        end
    end

endmodule
`default_nettype wire

[design/scpf_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scpf_queue
// Short first-in first-out queue of classified entries between the front
// end and the serializer.
// ----------------------------------------------------------------------------
module scpf_queue #(
    parameter int DEPTH = scpf_pkg::QDEPTH,
    parameter int W     = $bits(scpf_pkg::t_entry)
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_wr,
    input  wire [W-1:0]  i_data,
    input  wire          i_rd,
    output logic         o_full,
    output logic         o_empty,
    output logic [W-1:0] o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp, n_wp;
    logic [AW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_wr;
    logic          do_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];
    assign do_wr   = i_wr & ~o_full;
    assign do_rd   = i_rd & ~o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_wr) begin
            n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
        end
        if (do_rd) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
        end
        if (do_wr && !do_rd) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_rd && !do_wr) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

[design/scpf_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scpf_back
// Serializer: expands the queue head into header, payload and trailer bytes,
// one per cycle, into a registered output slot, while it is free or popped.
// ----------------------------------------------------------------------------
module scpf_back (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_valid,
    input  scpf_pkg::t_entry                i_entry,
    output logic                            o_rd,
    input  wire                             i_pop,
    output logic                            o_empty,
    output logic [scpf_pkg::BYTE_W-1:0]     o_byte,
    output logic                            o_end,
    output logic                            o_last
);

    localparam int BYTE_W = scpf_pkg::BYTE_W;

    scpf_pkg::t_step   r_step, n_step;
    logic              r_mid;
    scpf_pkg::t_step   cur_step;
    scpf_pkg::t_step   last_step;
    logic              is_last;
    logic              load;
    logic [BYTE_W-1:0] cur_byte;

    logic              r_ovalid;
    logic [BYTE_W-1:0] r_obyte;
    logic              r_oend;
    logic              r_olast;

    assign cur_step  = r_mid ? r_step
                     : (i_entry.hdr ? scpf_pkg::STEP_MAGIC0 : scpf_pkg::STEP_DATA);
    assign last_step = i_entry.tail ? scpf_pkg::STEP_STATUS : scpf_pkg::STEP_DATA;
    assign is_last   = (cur_step == last_step);
    assign load      = i_valid & (~r_ovalid | i_pop);
    assign o_rd      = load & is_last;

    // Next step
    always_comb begin
        unique case (cur_step)
            scpf_pkg::STEP_MAGIC0: n_step = scpf_pkg::STEP_MAGIC1;
            scpf_pkg::STEP_MAGIC1: n_step = scpf_pkg::STEP_CMD;
            scpf_pkg::STEP_CMD:    n_step = scpf_pkg::STEP_FLAG;
            scpf_pkg::STEP_FLAG:   n_step = scpf_pkg::STEP_LEN_LO;
            scpf_pkg::STEP_LEN_LO: n_step = scpf_pkg::STEP_LEN_HI;
            scpf_pkg::STEP_LEN_HI: n_step = scpf_pkg::STEP_DATA;
            scpf_pkg::STEP_DATA:   n_step = scpf_pkg::STEP_SUM_LO;
            scpf_pkg::STEP_SUM_LO: n_step = scpf_pkg::STEP_SUM_HI;
            scpf_pkg::STEP_SUM_HI: n_step = scpf_pkg::STEP_ACK;
            scpf_pkg::STEP_ACK:    n_step = scpf_pkg::STEP_STATUS;
            default:               n_step = scpf_pkg::STEP_MAGIC0;
        endcase
    end

    // Byte for the current step
    always_comb begin
        unique case (cur_step)
            scpf_pkg::STEP_MAGIC0: cur_byte = scpf_pkg::MAGIC_FIRST;
            scpf_pkg::STEP_MAGIC1: cur_byte = scpf_pkg::MAGIC_SECOND;
            scpf_pkg::STEP_CMD:    cur_byte = i_entry.cmd;
            scpf_pkg::STEP_FLAG:   cur_byte = i_entry.flag;
            scpf_pkg::STEP_LEN_LO: cur_byte = i_entry.len[7:0];
            scpf_pkg::STEP_LEN_HI: cur_byte = BYTE_W'(i_entry.len[scpf_pkg::LEN_W-1:8]);
            scpf_pkg::STEP_DATA:   cur_byte = i_entry.data;
            scpf_pkg::STEP_SUM_LO: cur_byte = i_entry.sum[7:0];
            scpf_pkg::STEP_SUM_HI: cur_byte = i_entry.sum[15:8];
            default:               cur_byte = scpf_pkg::TRAILER_ZERO;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid    <= 1'b0;
            r_step   <= scpf_pkg::STEP_MAGIC0;
            r_ovalid <= 1'b0;
        end else if (load) begin
            r_mid    <= ~is_last;
            r_step   <= n_step;
            r_ovalid <= 1'b1;
        end else if (i_pop) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_obyte <= cur_byte;
            r_oend  <= (cur_step == scpf_pkg::STEP_STATUS);
            r_olast <= is_last;
        end
    end

    assign o_empty = ~r_ovalid;
    assign o_byte  = r_obyte;
    assign o_end   = r_oend;
    assign o_last  = r_olast;

endmodule
`default_nettype wire

[design/sum_checksum_packet_framer.sv]
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted byte is written into the queue, then its first result
//   goes into the registered output slot once the slot is free or popped.
// Throughput: one output byte per cycle, set by the serializer, while the
//   queue holds an entry and the output slot is free or being popped.
// Reset: synchronous, active low; clears position, checksum, queue and output
//   slot, and loads the register defaults (command 4, flag 0, len 640).
// ----------------------------------------------------------------------------
// sum_checksum_packet_framer
// Cuts a byte stream into packets with a six-byte header and a four-byte
// trailer carrying a 16-bit additive checksum.
// ----------------------------------------------------------------------------
module sum_checksum_packet_framer #(
    parameter int MAX_PAYLOAD = scpf_pkg::MAX_PAYLOAD
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // input queue side
    input  wire                               push,
    output logic                              full,
    input  wire [scpf_pkg::BYTE_W-1:0]        i_data_byte,
    // result queue side
    output logic                              empty,
    input  wire                               pop,
    output logic [scpf_pkg::BYTE_W-1:0]       o_out_byte,
    output logic                              o_packet_end,
    output logic                              o_run_last,
    // configuration writes
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire [scpf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [scpf_pkg::LEN_W-1:0]         i_cfg_data
);

    // Configuration registers. The user must make writes land only while the
    // block is idle (unchecked here), so the front end can read them directly.
    scpf_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cmd  <= scpf_pkg::CMD_RESET;
            r_cfg.flag <= scpf_pkg::FLAG_RESET;
            r_cfg.len  <= scpf_pkg::LEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            // Drop writes to an index beyond the register list.
            unique case (scpf_pkg::t_cfg_idx'(i_cfg_index))
                scpf_pkg::CFG_COMMAND: r_cfg.cmd  <= i_cfg_data[7:0];
                scpf_pkg::CFG_FLAG:    r_cfg.flag <= i_cfg_data[7:0];
                scpf_pkg::CFG_LENGTH:  r_cfg.len  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front end: classify each byte (header before, trailer after) and
    // carry the running checksum into the entry.
    logic             q_wr;
    logic             q_rd;
    logic             q_full;
    logic             q_empty;
    scpf_pkg::t_entry f_entry;
    scpf_pkg::t_entry q_head;

    scpf_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_full  (q_full),
        .i_data  (i_data_byte),
        .i_cfg   (r_cfg),
        .o_wr    (q_wr),
        .o_entry (f_entry)
    );

    // Decoupling queue: lets the front keep taking payload bytes while the
    // serializer spends extra cycles on header and trailer bytes.
    scpf_queue #(
        .DEPTH (scpf_pkg::QDEPTH),
        .W     ($bits(scpf_pkg::t_entry))
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_data  (f_entry),
        .i_rd    (q_rd),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    assign full = q_full;

    // Back end: emit one framed byte per cycle into the output slot while the slot is free or popped.
    scpf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (~q_empty),
        .i_entry (q_head),
        .o_rd    (q_rd),
        .i_pop   (pop),
        .o_empty (empty),
        .o_byte  (o_out_byte),
        .o_end   (o_packet_end),
        .o_last  (o_run_last)
    );

endmodule
`default_nettype wire

[design/scpf_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scpf_checker
// Port-level checks of the framer's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module scpf_checker (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           empty,
    input wire                           pop,
    input wire [scpf_pkg::BYTE_W-1:0]    o_out_byte,
    input wire                           o_packet_end,
    input wire                           o_run_last
);

    // The status byte is always the last result of its input byte.
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_packet_end) |-> o_run_last)
        else $error("packet end without run last");

    // The status byte is zero.
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_packet_end) |-> (o_out_byte == scpf_pkg::TRAILER_ZERO))
        else $error("status byte not zero");

    // A waiting result holds until taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_byte)
                              && $stable(o_packet_end) && $stable(o_run_last)))
        else $error("result changed while stalled");

    // Reset leaves no result waiting.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result present after reset");

endmodule

bind sum_checksum_packet_framer scpf_checker u_scpf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .empty        (empty),
    .pop          (pop),
    .o_out_byte   (o_out_byte),
    .o_packet_end (o_packet_end),
    .o_run_last   (o_run_last)
);
`default_nettype wire

[bench/sum_checksum_packet_framer_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sum_checksum_packet_framer_test
// Self-checking bench for the checksum packet framer. A queue-fed driver
// pushes payload bytes, a bench-side framer predicts the header, payload and
// trailer bytes of each accepted item, and a monitor compares every popped
// byte with the oldest prediction.
// ----------------------------------------------------------------------------
module sum_checksum_packet_framer_test;
    import scpf_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_LIMIT = 10;
    // Index past the register list; the block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              packet_end;
        logic              run_last;
    } t_framed;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 push        = 1'b0;
    logic                 full;
    logic [BYTE_W-1:0]    i_data_byte = '0;
    logic                 empty;
    logic                 pop         = 1'b0;
    logic [BYTE_W-1:0]    o_out_byte;
    logic                 o_packet_end;
    logic                 o_run_last;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [LEN_W-1:0]     i_cfg_data  = '0;

    // Bench copy of the registers, tracking every accepted write.
    logic [BYTE_W-1:0] hdr_cmd    = CMD_RESET;
    logic [BYTE_W-1:0] hdr_flag   = FLAG_RESET;
    logic [LEN_W-1:0]  hdr_length = LEN_RESET;

    // Bench copy of the framing state: payload bytes taken in the open
    // packet and the checksum gathered so far.
    int unsigned       fill_count = 0;
    logic [SUM_W-1:0]  frame_sum  = '0;

    logic [BYTE_W-1:0] bytes_to_send[$];
    t_framed           framed_due[$];

    int          sender_idle_pct   = 0;
    int          receiver_idle_pct = 0;
    int          mismatches        = 0;
    int unsigned cycles            = 0;

    sum_checksum_packet_framer DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_data_byte  (i_data_byte),
        .empty        (empty),
        .pop          (pop),
        .o_out_byte   (o_out_byte),
        .o_packet_end (o_packet_end),
        .o_run_last   (o_run_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Framing predictor
    // ------------------------------------------------------------------------
    function automatic void add_due(input logic [BYTE_W-1:0] value,
                                    input logic pkt_end, input logic item_end);
        framed_due.push_back('{value, pkt_end, item_end});
    endfunction

    // Frame one accepted payload byte: open a packet with a header when none
    // is open, pass the byte, and close with the trailer once the fill reaches
    // the current length (a length shrunk below the fill closes at once).
    function automatic void frame_payload_byte(input logic [BYTE_W-1:0] data);
        int unsigned       span;
        logic [BYTE_W-1:0] len_lo;
        logic [BYTE_W-1:0] len_hi;
        logic              closes;
        // Clamp zero up to one and oversized lengths down to the maximum.
        span = (hdr_length == 0) ? 1 :
               ((hdr_length > MAX_PAYLOAD) ? MAX_PAYLOAD : hdr_length);
        len_lo = span[7:0];
        len_hi = span[15:8];
        closes = (fill_count + 1 >= span);
        if (fill_count == 0) begin
            add_due(MAGIC_FIRST,  1'b0, 1'b0);
            add_due(MAGIC_SECOND, 1'b0, 1'b0);
            add_due(hdr_cmd,      1'b0, 1'b0);
            add_due(hdr_flag,     1'b0, 1'b0);
            add_due(len_lo,       1'b0, 1'b0);
            add_due(len_hi,       1'b0, 1'b0);
            // Seed the checksum from the header fields, magic bytes excluded.
            frame_sum = SUM_W'(hdr_cmd) + SUM_W'(hdr_flag) + SUM_W'(len_lo)
                      + SUM_W'(len_hi);
        end
        add_due(data, 1'b0, !closes);
        frame_sum  = frame_sum + SUM_W'(data);
        fill_count = fill_count + 1;
        if (closes) begin
            add_due(frame_sum[7:0],  1'b0, 1'b0);
            add_due(frame_sum[15:8], 1'b0, 1'b0);
            add_due(TRAILER_ZERO,    1'b0, 1'b0);
            add_due(TRAILER_ZERO,    1'b1, 1'b1);
            fill_count = 0;
            frame_sum  = '0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driver: predict on each accepted item, then offer the next pending byte
    // unless the sender idles this cycle. Hold the offered byte while full.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (push && !full) begin
            frame_payload_byte(i_data_byte);
        end
        if (!push || !full) begin
            if (bytes_to_send.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                push        <= 1'b1;
                i_data_byte <= bytes_to_send.pop_front();
            end else begin
                push <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each accepted result against the oldest prediction, then
    // pick the next pop at random.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_framed want;
        if (i_rst_n && pop && !empty) begin
            if (framed_due.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("%0t: byte %02h with nothing predicted", $time, o_out_byte);
                end
            end else begin
                want = framed_due.pop_front();
                if (o_out_byte !== want.out_byte || o_packet_end !== want.packet_end ||
                    o_run_last !== want.run_last) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("%0t: expected byte %02h end %b last %b, got %02h end %b last %b",
                                 $time, want.out_byte, want.packet_end, want.run_last,
                                 o_out_byte, o_packet_end, o_run_last);
                    end
                end
            end
        end
        pop <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("sum_checksum_packet_framer_test: done, errors");
            $finish;
        end
    end

    // Hold until every pending byte is accepted and every prediction popped.
    task automatic wait_quiet();
        do @(negedge i_clk);
        while (bytes_to_send.size() != 0 || push || framed_due.size() != 0);
    endtask

    // Write one register and mirror it in the bench copy once accepted.
    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [LEN_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_COMMAND: hdr_cmd    = value[BYTE_W-1:0];
            CFG_FLAG:    hdr_flag   = value[BYTE_W-1:0];
            CFG_LENGTH:  hdr_length = value;
            default:     ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int               phase;
        int               count;
        int               pick;
        logic [LEN_W-1:0] len_choice;

        // Sender idles lightly, receiver heavily.
        sender_idle_pct   = 15;
        receiver_idle_pct = 52;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset registers: header carries length 640 and the packet stays open.
        bytes_to_send.push_back(8'h00);
        bytes_to_send.push_back(8'hFF);
        wait_quiet();

        // Shrink the length below the fill mid-packet: close after the next
        // byte, then run one-byte packets.
        write_setting(CFG_LENGTH, 11'd1);
        bytes_to_send.push_back(8'hA5);
        bytes_to_send.push_back(8'h00);
        bytes_to_send.push_back(8'hFF);
        wait_quiet();

        // All-ones command and flag (upper data bits dropped), zero length
        // treated as one.
        write_setting(CFG_COMMAND, 11'h7FF);
        write_setting(CFG_FLAG, 11'h0FF);
        write_setting(CFG_LENGTH, 11'd0);
        bytes_to_send.push_back(8'hFF);
        bytes_to_send.push_back(8'h00);
        wait_quiet();

        // Oversized length saturates to the maximum in the header.
        write_setting(CFG_COMMAND, 11'h000);
        write_setting(CFG_FLAG, 11'h000);
        write_setting(CFG_LENGTH, 11'h7FF);
        bytes_to_send.push_back(8'h55);
        bytes_to_send.push_back(8'hAA);
        bytes_to_send.push_back(8'h01);
        wait_quiet();

        // Change command, flag and length mid-packet: the open packet closes
        // at the new length, the new command and flag show up in the next
        // header only. The spare index must change nothing.
        write_setting(CFG_COMMAND, 11'h05A);
        write_setting(CFG_FLAG, 11'h0C3);
        write_setting(CFG_LENGTH, 11'd5);
        write_setting(CFG_SPARE, 11'h7FF);
        bytes_to_send.push_back(8'h10);
        bytes_to_send.push_back(8'h20);
        bytes_to_send.push_back(8'h30);
        wait_quiet();

        // Exact maximum length.
        write_setting(CFG_LENGTH, 11'd1024);
        bytes_to_send.push_back(8'h80);
        bytes_to_send.push_back(8'h7F);
        wait_quiet();

        // Random phases: new settings each time, mostly short packets so
        // headers and trailers come often. Swap the idle pressure halfway.
        for (phase = 0; phase < 8; phase++) begin
            if (phase == 4) begin
                sender_idle_pct   = 52;
                receiver_idle_pct = 15;
            end
            if ($urandom_range(1)) write_setting(CFG_COMMAND, LEN_W'($urandom_range(2047)));
            if ($urandom_range(1)) write_setting(CFG_FLAG, LEN_W'($urandom_range(2047)));
            pick = $urandom_range(19);
            if (pick == 0) begin
                len_choice = '0;
            end else if (pick == 1) begin
                len_choice = LEN_W'($urandom_range(2047, 17));
            end else begin
                len_choice = LEN_W'($urandom_range(12, 1));
            end
            write_setting(CFG_LENGTH, len_choice);
            if ($urandom_range(3) == 0) write_setting(CFG_SPARE, LEN_W'($urandom_range(2047)));
            count = $urandom_range(14, 8);
            repeat (count) bytes_to_send.push_back(BYTE_W'($urandom_range(255)));
            // Pause the sender until everything predicted has come out.
            wait_quiet();
        end

        // Long packet of high bytes with no idling: the checksum wraps past
        // 16 bits. Close any open packet first so it starts fresh.
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        write_setting(CFG_LENGTH, 11'd1);
        bytes_to_send.push_back(BYTE_W'($urandom_range(255)));
        wait_quiet();
        write_setting(CFG_COMMAND, 11'h0FF);
        write_setting(CFG_FLAG, 11'h0FF);
        write_setting(CFG_LENGTH, 11'd270);
        repeat (270) bytes_to_send.push_back(BYTE_W'($urandom_range(255, 248)));
        wait_quiet();

        // Let any stray output show up before the verdict.
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("sum_checksum_packet_framer_test: done, clean");
        end else begin
            $display("sum_checksum_packet_framer_test: done, errors");
        end
        $finish;
    end

endmodule

[filelist.f]
design/scpf_pkg.sv
design/scpf_front.sv
design/scpf_queue.sv
design/scpf_back.sv
design/sum_checksum_packet_framer.sv
design/scpf_checker.sv
bench/sum_checksum_packet_framer_test.sv
